// ----- hw/rtl/hpd_pkg.sv -----
package hpd_pkg;

	// sizes fixed by the item and register fields
	localparam int RAW_W   = 12;
	localparam int LEVEL_W = 10;
	localparam int TIME_W  = 13;
	localparam int RATE_W  = 10;

	// build-time choices
	localparam int SAMPLE_BITS   = 12;
	localparam int HISTORY_DEPTH = 10;

	localparam int LEVEL_MAX   = (1 << LEVEL_W) - 1;
	localparam int ELAPSED_MAX = (1 << TIME_W) - 1;
	localparam int MS_PER_MIN  = 60000;
	localparam int MS_PER_MIN_W = 16;
	localparam int SAMPLE_FULL = (1 << SAMPLE_BITS) - 1;
	localparam int SETTLE_DIV  = 5;

	// scaled sample product x * 1023
	localparam int SCALE_W = SAMPLE_BITS + LEVEL_W;
	localparam int SUM_W   = $clog2(HISTORY_DEPTH * ELAPSED_MAX + 1);

	// reciprocal multiplies, exact over the whole operand range
	localparam int SETTLE_SHIFT = TIME_W + 3;
	localparam int SETTLE_RECIP = ((1 << SETTLE_SHIFT) + SETTLE_DIV - 1) / SETTLE_DIV;
	localparam int AVG_SHIFT    = SUM_W + 4;
	localparam int AVG_RECIP    = ((1 << AVG_SHIFT) + HISTORY_DEPTH - 1) / HISTORY_DEPTH;

	// shared divider widths
	localparam int DVD_W = MS_PER_MIN_W;
	localparam int DVS_W = TIME_W;
	localparam int CNT_W = $clog2(DVD_W + 1);

	// configuration registers
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TICK_MS     = 3'd0,
		CFG_MIN_GAP     = 3'd1,
		CFG_TIMEOUT     = 3'd2,
		CFG_DEF_THRESH  = 3'd3,
		CFG_DEF_LEVEL   = 3'd4
	} cfg_reg_e;

	localparam logic [4:0]         RST_TICK_MS    = 5'd2;
	localparam logic [9:0]         RST_MIN_GAP    = 10'd250;
	localparam logic [11:0]        RST_TIMEOUT    = 12'd2500;
	localparam logic [LEVEL_W-1:0] RST_THRESHOLD  = 10'd530;
	localparam logic [LEVEL_W-1:0] RST_LEVEL      = 10'd512;
	localparam logic [TIME_W-1:0]  RST_INTERVAL   = 13'd600;

	typedef struct packed {
		logic [4:0]         tick_ms;
		logic [9:0]         min_beat_gap_ms;
		logic [11:0]        no_beat_timeout_ms;
		logic [LEVEL_W-1:0] default_threshold;
		logic [LEVEL_W-1:0] default_level;
	} cfg_t;

	typedef struct packed {
		logic [RAW_W-1:0] sample_raw;
	} sample_t;

	typedef struct packed {
		logic [RATE_W-1:0]  bpm;
		logic               beat_valid;
		logic               pulse_active;
		logic [TIME_W-1:0]  interval_ms;
		logic [LEVEL_W-1:0] current_threshold;
	} result_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
		logic [CNT_W-1:0] nbits;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic fill;
		logic shift;
	} hist_ctl_t;

endpackage

// ----- hw/rtl/hpd_intf.sv -----
interface hpd_sample_if;
	logic             valid;
	logic             ready;
	hpd_pkg::sample_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface hpd_result_if;
	logic             valid;
	logic             ready;
	hpd_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/hpd_cfg.sv -----
module hpd_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [hpd_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [hpd_pkg::CFG_DATA_W-1:0]    cfg_data,
	output hpd_pkg::cfg_t                     cfg
);

	hpd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_ms            <= hpd_pkg::RST_TICK_MS;
			cfg_q.min_beat_gap_ms    <= hpd_pkg::RST_MIN_GAP;
			cfg_q.no_beat_timeout_ms <= hpd_pkg::RST_TIMEOUT;
			cfg_q.default_threshold  <= hpd_pkg::RST_THRESHOLD;
			cfg_q.default_level      <= hpd_pkg::RST_LEVEL;
		end else if (cfg_we) begin
			// unknown index is dropped
			case (cfg_idx)
				hpd_pkg::CFG_TICK_MS:    cfg_q.tick_ms <= cfg_data[4:0];
				hpd_pkg::CFG_MIN_GAP:    cfg_q.min_beat_gap_ms <= cfg_data[9:0];
				hpd_pkg::CFG_TIMEOUT:    cfg_q.no_beat_timeout_ms <= cfg_data[11:0];
				hpd_pkg::CFG_DEF_THRESH: cfg_q.default_threshold <= cfg_data[9:0];
				hpd_pkg::CFG_DEF_LEVEL:  cfg_q.default_level <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hw/rtl/hpd_div.sv -----
module hpd_div (
	input  logic              clk,
	input  logic              arst_n,
	input  hpd_pkg::div_req_t req,
	output hpd_pkg::div_rsp_t rsp
);

	localparam int DVD_W = hpd_pkg::DVD_W;
	localparam int DVS_W = hpd_pkg::DVS_W;
	localparam int CNT_W = hpd_pkg::CNT_W;

	logic [DVD_W-1:0] dvd_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [CNT_W-1:0] count_q;
	logic             busy_q;
	logic             done_q;

	logic [DVS_W:0] trial;
	logic           fits;

	// one restoring step per cycle, dividend taken msb first
	always_comb begin
		trial = {rem_q, dvd_q[DVD_W-1]};
		fits  = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
			dvd_q   <= '0;
			quo_q   <= '0;
			dvs_q   <= '0;
			rem_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				dvd_q   <= req.dividend;
				dvs_q   <= req.divisor;
				quo_q   <= '0;
				rem_q   <= '0;
				count_q <= req.nbits;
				busy_q  <= 1'b1;
			end else if (busy_q) begin
				dvd_q   <= dvd_q << 1;
				quo_q   <= {quo_q[DVD_W-2:0], fits};
				rem_q   <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
				count_q <= count_q - CNT_W'(1);
				if (count_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ----- hw/rtl/hpd_hist.sv -----
module hpd_hist (
	input  logic                          clk,
	input  hpd_pkg::hist_ctl_t            ctl,
	input  logic [hpd_pkg::TIME_W-1:0]    since,
	output logic [hpd_pkg::SUM_W-1:0]     sum
);

	localparam int DEPTH = hpd_pkg::HISTORY_DEPTH;
	localparam int SUM_W = hpd_pkg::SUM_W;

	logic [hpd_pkg::TIME_W-1:0] hist_q [DEPTH];
	logic [SUM_W-1:0]           sum_q;

	// running sum: fill loads every entry with since; on shift the oldest entry leaves, newest enters
	always_ff @(posedge clk) begin
		if (ctl.fill) begin
			for (int i = 0; i < DEPTH; i++) begin
				hist_q[i] <= since;
			end
			sum_q <= SUM_W'(since) * SUM_W'(DEPTH);
		end else if (ctl.shift) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				hist_q[i] <= hist_q[i+1];
			end
			hist_q[DEPTH-1] <= since;
			sum_q <= sum_q - SUM_W'(hist_q[0]) + SUM_W'(since);
		end
	end

	assign sum = sum_q;

endmodule

// ----- hw/rtl/heartbeat_pulse_detector.sv -----
// heartbeat_pulse_detector: optical pulse beat detector with an averaged rate
//
// sample: one transaction per converter reading (sample_raw). report: one
// transaction per sample with bpm, beat_valid, pulse_active, interval_ms and
// current_threshold. configuration is a plain write port (cfg_we, cfg_idx,
// cfg_data); the user must write it only while the block is idle, as the
// block does not enforce it. scaling, settle time and the history average
// are constant divisions done with a fold and reciprocal multiplies; only
// 60000/average runs through the restoring divider (16 steps) under a small
// sequencer. states per sample: scale, eval, finish, done; an arming beat
// skips finish; a rate-producing beat adds avg, rate and the divider wait.
// a new sample is taken only after the previous one's report is registered.
// reset: registers take their default values, elapsed time is zero and the
// block waits for an arming beat. the interval history is not cleared.
// a finished report is held in an output register; the next sample is taken
// while it waits, but that sample's result stalls until report is taken.
module heartbeat_pulse_detector (
	input  logic                              clk,
	input  logic                              arst_n,
	hpd_sample_if.sink                        sample,
	hpd_result_if.source                      report,
	input  logic                              cfg_we,
	input  logic [hpd_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [hpd_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int LEVEL_W = hpd_pkg::LEVEL_W;
	localparam int TIME_W  = hpd_pkg::TIME_W;
	localparam int DVD_W   = hpd_pkg::DVD_W;
	localparam int DVS_W   = hpd_pkg::DVS_W;
	localparam int CNT_W   = hpd_pkg::CNT_W;
	localparam int SUM_W   = hpd_pkg::SUM_W;
	localparam int RATE_W  = hpd_pkg::RATE_W;
	localparam int SB      = hpd_pkg::SAMPLE_BITS;
	localparam int SCALE_W = hpd_pkg::SCALE_W;
	localparam int SETTLE_PROD_W = TIME_W + hpd_pkg::SETTLE_SHIFT;
	localparam int AVG_PROD_W    = SUM_W + hpd_pkg::AVG_SHIFT;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCALE,
		ST_EVAL,
		ST_AVG,
		ST_RATE,
		ST_RATE_W,
		ST_FINISH,
		ST_DONE
	} state_t;

	state_t state_q;

	hpd_pkg::cfg_t      cfg;
	hpd_pkg::div_req_t  div_req;
	hpd_pkg::div_rsp_t  div_rsp;
	hpd_pkg::hist_ctl_t hist_ctl;
	logic [SUM_W-1:0]   hist_sum;

	// per-sample working registers
	logic [hpd_pkg::RAW_W-1:0] raw_q;
	logic [LEVEL_W-1:0]        sig_q;
	logic [TIME_W-1:0]         since_q;
	logic [TIME_W-1:0]         settle_q;
	logic [TIME_W-1:0]         avg_q;
	logic [RATE_W-1:0]         rate_q;
	logic                      valid_q;

	// detector state
	logic [TIME_W-1:0]  elapsed_q;
	logic [TIME_W-1:0]  last_int_q;
	logic [LEVEL_W-1:0] peak_q;
	logic [LEVEL_W-1:0] trough_q;
	logic [LEVEL_W-1:0] thr_q;
	logic               in_beat_q;
	logic               await_first_q;
	logic               await_second_q;

	hpd_pkg::result_t out_q;
	logic             out_valid_q;

	hpd_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	hpd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	hpd_hist u_hist (
		.clk   (clk),
		.ctl   (hist_ctl),
		.since (since_q),
		.sum   (hist_sum)
	);

	// elapsed time plus one tick, held at the 13-bit ceiling
	logic [TIME_W:0]     elapsed_sum;
	logic [TIME_W-1:0]   since_next;
	logic [SB-1:0]       sample_bits;
	logic [SCALE_W-1:0]  scaled_num;
	logic [SCALE_W-1:0]  scaled_fold;
	logic [LEVEL_W-1:0]  sig_next;

	always_comb begin
		elapsed_sum = {1'b0, elapsed_q} + (TIME_W+1)'(cfg.tick_ms);
		since_next  = elapsed_sum[TIME_W] ? TIME_W'(hpd_pkg::ELAPSED_MAX)
		                                  : elapsed_sum[TIME_W-1:0];
		sample_bits = SB'(raw_q);
		// x * 1023 as x*1024 - x
		scaled_num  = (SCALE_W'(sample_bits) << LEVEL_W) - SCALE_W'(sample_bits);
		// divide by 2^SB - 1: fold the high part back in, exact below 2^(2*SB) - 1
		scaled_fold = scaled_num + (scaled_num >> SB) + SCALE_W'(1);
		sig_next    = scaled_fold[SB +: LEVEL_W];
	end

	// settle time (interval / 5) * 3 and history average, by reciprocal multiply
	logic [SETTLE_PROD_W-1:0] settle_prod;
	logic [TIME_W-1:0]        settle_fifth;
	logic [TIME_W-1:0]        settle_next;
	logic [AVG_PROD_W-1:0]    avg_prod;
	logic [TIME_W-1:0]        avg_next;

	always_comb begin
		settle_prod  = SETTLE_PROD_W'(last_int_q) * SETTLE_PROD_W'(hpd_pkg::SETTLE_RECIP);
		settle_fifth = settle_prod[hpd_pkg::SETTLE_SHIFT +: TIME_W];
		settle_next  = TIME_W'({settle_fifth, 1'b0}) + settle_fifth;
		avg_prod     = AVG_PROD_W'(hist_sum) * AVG_PROD_W'(hpd_pkg::AVG_RECIP);
		avg_next     = avg_prod[hpd_pkg::AVG_SHIFT +: TIME_W];
	end

	// threshold and beat decisions on the scaled sample
	logic               sig_lo;
	logic               sig_hi;
	logic               past_settle;
	logic               beat;
	logic [LEVEL_W-1:0] peak_next;
	logic [LEVEL_W-1:0] trough_next;

	always_comb begin
		sig_lo      = sig_q < thr_q;
		sig_hi      = sig_q > thr_q;
		past_settle = since_q > settle_q;
		beat        = (since_q > TIME_W'(cfg.min_beat_gap_ms)) && sig_hi &&
		              !in_beat_q && past_settle;
		trough_next = (sig_lo && past_settle && sig_q < trough_q) ? sig_q : trough_q;
		peak_next   = (sig_hi && sig_q > peak_q) ? sig_q : peak_q;
	end

	// falling crossing: trough plus half the swing, rounding toward zero;
	// the result always lies between trough and peak, so no clamp is needed
	logic signed [LEVEL_W+1:0] swing;
	logic signed [LEVEL_W+1:0] half_swing;
	logic signed [LEVEL_W+1:0] mid_level;

	always_comb begin
		swing      = $signed({2'b00, peak_q}) - $signed({2'b00, trough_q});
		half_swing = (swing + ((swing < 0) ? (LEVEL_W+2)'(1) : (LEVEL_W+2)'(0))) >>> 1;
		mid_level  = half_swing + $signed({2'b00, trough_q});
	end

	// divider requests and history control by state
	always_comb begin
		div_req  = '0;
		hist_ctl = '0;
		unique case (state_q)
			ST_EVAL: begin
				hist_ctl.fill  = beat && !await_first_q && await_second_q;
				hist_ctl.shift = beat && !await_first_q && !await_second_q;
			end
			ST_RATE: begin
				div_req.start    = avg_q != '0;
				div_req.dividend = DVD_W'(hpd_pkg::MS_PER_MIN);
				div_req.divisor  = DVS_W'(avg_q);
				div_req.nbits    = CNT_W'(DVD_W);
			end
			default: ;
		endcase
	end

	// sequencer, detector state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			raw_q          <= '0;
			sig_q          <= '0;
			since_q        <= '0;
			settle_q       <= '0;
			avg_q          <= '0;
			rate_q         <= '0;
			valid_q        <= 1'b0;
			elapsed_q      <= '0;
			last_int_q     <= hpd_pkg::RST_INTERVAL;
			peak_q         <= hpd_pkg::RST_LEVEL;
			trough_q       <= hpd_pkg::RST_LEVEL;
			thr_q          <= hpd_pkg::RST_THRESHOLD;
			in_beat_q      <= 1'b0;
			await_first_q  <= 1'b1;
			await_second_q <= 1'b0;
			out_q          <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			// a report taken while the next one is loaded stays valid
			if (out_valid_q && report.ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (sample.valid) begin
						raw_q   <= sample.data.sample_raw;
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					since_q  <= since_next;
					sig_q    <= sig_next;
					settle_q <= settle_next;
					state_q  <= ST_EVAL;
				end
				ST_EVAL: begin
					peak_q   <= peak_next;
					trough_q <= trough_next;
					rate_q   <= '0;
					valid_q  <= 1'b0;
					if (beat) begin
						in_beat_q  <= 1'b1;
						last_int_q <= since_q;
						elapsed_q  <= '0;
						if (await_first_q) begin
							// arming beat: no rate, no crossing or timeout check
							await_first_q  <= 1'b0;
							await_second_q <= 1'b1;
							state_q        <= ST_DONE;
						end else begin
							await_second_q <= 1'b0;
							state_q        <= ST_AVG;
						end
					end else begin
						elapsed_q <= since_q;
						state_q   <= ST_FINISH;
					end
				end
				ST_AVG: begin
					// history sum already holds this beat
					avg_q   <= avg_next;
					state_q <= ST_RATE;
				end
				ST_RATE: begin
					valid_q <= 1'b1;
					if (avg_q == '0) begin
						rate_q  <= RATE_W'(hpd_pkg::LEVEL_MAX);
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_RATE_W;
					end
				end
				ST_RATE_W: begin
					if (div_rsp.done) begin
						rate_q  <= (div_rsp.quotient > DVD_W'(hpd_pkg::LEVEL_MAX))
						           ? RATE_W'(hpd_pkg::LEVEL_MAX)
						           : div_rsp.quotient[RATE_W-1:0];
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					// timeout wins over the falling crossing, except for in_beat
					if (sig_lo && in_beat_q) begin
						in_beat_q <= 1'b0;
					end
					if (since_q > TIME_W'(cfg.no_beat_timeout_ms)) begin
						thr_q          <= cfg.default_threshold;
						peak_q         <= cfg.default_level;
						trough_q       <= cfg.default_level;
						elapsed_q      <= '0;
						await_first_q  <= 1'b1;
						await_second_q <= 1'b0;
					end else if (sig_lo && in_beat_q) begin
						thr_q     <= mid_level[LEVEL_W-1:0];
						peak_q    <= mid_level[LEVEL_W-1:0];
						trough_q  <= mid_level[LEVEL_W-1:0];
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || report.ready) begin
						out_q.bpm               <= rate_q;
						out_q.beat_valid        <= valid_q;
						out_q.pulse_active      <= in_beat_q;
						out_q.interval_ms       <= last_int_q;
						out_q.current_threshold <= thr_q;
						out_valid_q             <= 1'b1;
						state_q                 <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign sample.ready = state_q == ST_IDLE;
	assign report.valid = out_valid_q;
	assign report.data  = out_q;

	// no new sample while the divider is still working
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.busy |-> !sample.ready)
		else $error("sample accepted while divider busy");

	// a taken sample keeps the sequencer busy on the next cycle
	a_accept_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready) |=> !sample.ready)
		else $error("sequencer did not start on accepted sample");

	// a reported rate is never zero and no rate means zero
	a_rate_flag: assert property (@(posedge clk) disable iff (!arst_n)
		report.valid |-> (report.data.beat_valid == (report.data.bpm != '0)))
		else $error("bpm and beat_valid disagree");

	// the two arming flags are never set together
	a_arming: assert property (@(posedge clk) disable iff (!arst_n)
		!(await_first_q && await_second_q))
		else $error("arming flags both set");

endmodule
